[sv/afl_pkg.sv]
// Package for the airfoil coefficient lookup: coefficient tables, fixed-point
// constants and the types shared by the channels, the lane and the top level.
// No dependencies.
package afl_pkg;

    typedef logic signed [18:0] t_coef;   // table entry, units of 1e-5
    typedef logic signed [18:0] t_lift;   // Q2.16 signed
    typedef logic        [17:0] t_drag;   // Q2.16 unsigned

    localparam int WING_POINTS = 9;
    localparam int TAIL_POINTS = 7;

    // Angle limits in Q8.8, widened to 17 bits for the offset math
    localparam logic signed [16:0] WING_START = -17'sd2048;
    localparam logic signed [16:0] WING_END   = 17'sd6144;
    localparam logic        [15:0] TAIL_END   = 16'd6144;

    localparam logic signed [15:0] FLAP_ONE     = 16'sd16384;
    localparam t_drag              OUT_DRAG_Q16 = 18'd49152;

    // n / (2^13 * 3125), rounded: add half the divisor, shift by 13, then
    // divide by 3125 through a reciprocal with one correction step.
    localparam logic [42:0] ROUND_BIAS   = 43'd12800000;
    localparam int          ROUND_SHIFT  = 13;
    localparam logic [11:0] SCALE_DIV    = 12'd3125;
    localparam logic [28:0] RECIP_M      = 29'd351843720;   // floor(2^40 / 3125)
    localparam int          RECIP_SHIFT  = 40;

    localparam t_coef WING_CL_MID [WING_POINTS] = '{
        -19'sd54000, -19'sd20000, 19'sd20000, 19'sd57000, 19'sd92000,
        19'sd121000, 19'sd143000, 19'sd140000, 19'sd100000};
    localparam t_coef WING_CL_DOWN [WING_POINTS] = '{
        19'sd0, 19'sd45000, 19'sd85000, 19'sd102000, 19'sd139000,
        19'sd165000, 19'sd175000, 19'sd138000, 19'sd117000};
    localparam t_coef WING_CL_UP [WING_POINTS] = '{
        -19'sd74000, -19'sd40000, 19'sd0, 19'sd27000, 19'sd63000,
        19'sd92000, 19'sd103000, 19'sd110000, 19'sd78000};
    localparam t_coef WING_CD_MID [WING_POINTS] = '{
        19'sd1000, 19'sd740, 19'sd400, 19'sd900, 19'sd1300,
        19'sd2300, 19'sd5000, 19'sd12000, 19'sd21000};
    localparam t_coef WING_CD_DOWN [WING_POINTS] = '{
        19'sd650, 19'sd430, 19'sd550, 19'sd1530, 19'sd2210,
        19'sd3910, 19'sd10000, 19'sd19500, 19'sd30000};
    localparam t_coef WING_CD_UP [WING_POINTS] = '{
        19'sd500, 19'sd430, 19'sd550, 19'sd2601, 19'sd3757,
        19'sd6647, 19'sd13000, 19'sd18000, 19'sd25000};
    localparam t_coef TAIL_CL [TAIL_POINTS] = '{
        19'sd0, 19'sd45600, 19'sd73600, 19'sd96800, 19'sd114400,
        19'sd112000, 19'sd80000};
    localparam t_coef TAIL_CD [TAIL_POINTS] = '{
        19'sd320, 19'sd720, 19'sd1040, 19'sd1840, 19'sd4000,
        19'sd9600, 19'sd16800};

    // Segment end points for one coefficient: neutral table and blend target
    typedef struct packed {
        t_coef lo_m;
        t_coef hi_m;
        t_coef lo_o;
        t_coef hi_o;
    } t_lane_in;

endpackage

[sv/afl_if.sv]
// Channel interfaces of the airfoil coefficient lookup: angle in, coefficients out.
// Depends on afl_pkg.
interface afl_in_if import afl_pkg::*;;
    logic               valid;
    logic               ready;
    logic               action;
    logic signed [15:0] angle_deg;
    logic signed [15:0] flap_setting;

    modport source (output valid, action, angle_deg, flap_setting, input ready);
    modport sink   (input valid, action, angle_deg, flap_setting, output ready);
endinterface

interface afl_out_if import afl_pkg::*;;
    logic  valid;
    logic  ready;
    t_lift lift_coeff;
    t_drag drag_coeff;

    modport source (output valid, lift_coeff, drag_coeff, input ready);
    modport sink   (input valid, lift_coeff, drag_coeff, output ready);
endinterface

[sv/afl_lane.sv]
// Arithmetic lane for one coefficient: interpolation, flap blend and rounding
// to Q2.16 over four register stages. Depends on afl_pkg.
module afl_lane import afl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  t_lane_in    i_tab,
    input  logic [9:0]  i_frac,
    input  logic [14:0] i_flap_mag,
    output logic [17:0] o_mag,
    output logic        o_neg
);

    // stage 2: interpolate both tables
    logic signed [19:0] w_dm, w_do;
    logic signed [30:0] w_pm, w_po;
    logic signed [29:0] n_base_m, n_base_o, r_base_m, r_base_o;
    logic        [14:0] r_af;

    // stage 3: blend
    logic signed [30:0] w_diff;
    logic signed [46:0] w_blend;
    logic signed [47:0] n_n, r_n;

    // stage 4: magnitude, half bias, shift
    logic        [42:0] w_mag;
    logic        [43:0] w_sum;
    logic        [29:0] n_t, r_t;
    logic               r_neg4;

    // stage 5: reciprocal multiply
    logic        [58:0] w_prod;
    logic        [18:0] r_q0;
    logic        [29:0] r_t5;
    logic               r_neg5;

    // final correction (registered by the top level)
    logic        [30:0] w_back, w_rem;
    logic        [18:0] w_q;

    always_comb begin
        w_dm     = 20'(i_tab.hi_m) - 20'(i_tab.lo_m);
        w_do     = 20'(i_tab.hi_o) - 20'(i_tab.lo_o);
        w_pm     = w_dm * $signed({1'b0, i_frac});
        w_po     = w_do * $signed({1'b0, i_frac});
        n_base_m = (30'(i_tab.lo_m) <<< 10) + w_pm[29:0];
        n_base_o = (30'(i_tab.lo_o) <<< 10) + w_po[29:0];

        w_diff   = 31'(r_base_o) - 31'(r_base_m);
        w_blend  = w_diff * $signed({1'b0, r_af});
        n_n      = (48'(r_base_m) <<< 14) + 48'(w_blend);

        w_mag    = r_n[47] ? 43'(-r_n) : r_n[42:0];
        w_sum    = {1'b0, w_mag} + {1'b0, ROUND_BIAS};
        n_t      = w_sum[ROUND_SHIFT +: 30];

        w_prod   = r_t * RECIP_M;

        w_back   = r_q0 * SCALE_DIV;
        w_rem    = {1'b0, r_t5} - w_back;
        w_q      = (w_rem >= {19'd0, SCALE_DIV}) ? (r_q0 + 19'd1) : r_q0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_base_m <= n_base_m;
            r_base_o <= n_base_o;
            r_af     <= i_flap_mag;
            r_n      <= n_n;
            r_t      <= n_t;
            r_neg4   <= r_n[47];
            r_q0     <= w_prod[RECIP_SHIFT +: 19];
            r_t5     <= r_t;
            r_neg5   <= r_neg4;
        end
    end

    assign o_mag = w_q[17:0];
    assign o_neg = r_neg5;

endmodule

[sv/airfoil_coefficient_lookup_core.sv]
// Airfoil coefficient lookup, top level.
// Depends on afl_pkg, afl_if (afl_in_if, afl_out_if) and afl_lane.
//
// Usage:
//   i_in  carries one lookup per transfer: action (0 wing section, 1 tail
//         surface), angle_deg (Q8.8) and flap_setting (Q1.14, wing only).
//   o_out returns one result per lookup, in order: lift_coeff (signed Q2.16)
//         and drag_coeff (Q2.16). Out-of-range angles give lift 0, drag 0.75.
// Throughput: one lookup per cycle while o_out is not stalling; the pipeline has six register
//   stages (table fetch, interpolation, blend, round bias, reciprocal multiply,
//   output register).
// Stall: the whole pipeline advances together. i_in.ready is high whenever the
//   output register is empty or being taken, so a stalled receiver holds every
//   stage in place and backs up into i_in.ready; nothing is lost or repeated.
// Reset: synchronous, active low; clears all valid bits. No tables to load,
//   so the block accepts lookups on the first cycle after reset.
module airfoil_coefficient_lookup_core import afl_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    afl_in_if.sink    i_in,
    afl_out_if.source o_out
);

    localparam int CTL_STAGES = 5;

    typedef struct packed {
        logic valid;
        logic in_range;
        logic tail_neg;     // tail surface with negative angle: flip lift
    } t_ctrl;

    logic w_en;

    // stage 1 decode
    logic signed [15:0] w_flap;
    logic        [14:0] n_af, r_af;
    logic signed [16:0] w_off;
    logic        [15:0] w_abs;
    logic               w_wing_rng, w_tail_rng;
    logic        [3:0]  w_wi, w_wi1;
    logic        [2:0]  w_ti, w_ti1;
    logic        [9:0]  n_frac, r_frac;
    t_lane_in           n_cl, n_cd, r_cl, r_cd;
    t_ctrl              n_ctl;
    t_ctrl              r_ctl [CTL_STAGES];

    // lane outputs
    logic        [17:0] w_cl_mag, w_cd_mag;
    logic               w_cl_neg, w_cd_neg;

    // output stage
    logic               n_ov, r_ov;
    t_lift              n_lift, r_lift;
    t_drag              n_drag, r_drag;

    assign w_en       = !r_ov || o_out.ready;
    assign i_in.ready = w_en;

    // Table fetch: saturate flap, locate segment, pick the wing blend target by flap sign
    always_comb begin
        if (i_in.flap_setting > FLAP_ONE) begin
            w_flap = FLAP_ONE;
        end else if (i_in.flap_setting < -FLAP_ONE) begin
            w_flap = -FLAP_ONE;
        end else begin
            w_flap = i_in.flap_setting;
        end

        w_off      = 17'(i_in.angle_deg) - WING_START;
        w_wing_rng = (17'(i_in.angle_deg) >= WING_START) && (17'(i_in.angle_deg) < WING_END);
        w_abs      = i_in.angle_deg[15] ? 16'(-17'(i_in.angle_deg)) : 16'(i_in.angle_deg);
        w_tail_rng = w_abs < TAIL_END;

        w_wi  = {1'b0, w_off[12:10]};
        w_wi1 = w_wi + 4'd1;
        w_ti  = w_tail_rng ? w_abs[12:10] : 3'd0;   // keep index inside the tail table
        w_ti1 = w_ti + 3'd1;

        n_cl = '0;
        n_cd = '0;
        if (i_in.action) begin
            n_cl.lo_m = TAIL_CL[w_ti];
            n_cl.hi_m = TAIL_CL[w_ti1];
            n_cl.lo_o = TAIL_CL[w_ti];
            n_cl.hi_o = TAIL_CL[w_ti1];
            n_cd.lo_m = TAIL_CD[w_ti];
            n_cd.hi_m = TAIL_CD[w_ti1];
            n_cd.lo_o = TAIL_CD[w_ti];
            n_cd.hi_o = TAIL_CD[w_ti1];
            n_frac    = w_abs[9:0];
            n_af      = 15'd0;                       // flap ignored on tail
        end else begin
            n_cl.lo_m = WING_CL_MID[w_wi];
            n_cl.hi_m = WING_CL_MID[w_wi1];
            n_cd.lo_m = WING_CD_MID[w_wi];
            n_cd.hi_m = WING_CD_MID[w_wi1];
            if (w_flap[15]) begin
                n_cl.lo_o = WING_CL_DOWN[w_wi];
                n_cl.hi_o = WING_CL_DOWN[w_wi1];
                n_cd.lo_o = WING_CD_DOWN[w_wi];
                n_cd.hi_o = WING_CD_DOWN[w_wi1];
            end else begin
                n_cl.lo_o = WING_CL_UP[w_wi];
                n_cl.hi_o = WING_CL_UP[w_wi1];
                n_cd.lo_o = WING_CD_UP[w_wi];
                n_cd.hi_o = WING_CD_UP[w_wi1];
            end
            n_frac = w_off[9:0];
            n_af   = w_flap[15] ? 15'(-w_flap) : w_flap[14:0];
        end

        n_ctl.valid    = i_in.valid;
        n_ctl.in_range = i_in.action ? w_tail_rng : w_wing_rng;
        n_ctl.tail_neg = i_in.action && i_in.angle_deg[15];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cl   <= n_cl;
            r_cd   <= n_cd;
            r_frac <= n_frac;
            r_af   <= n_af;
        end
    end

    afl_lane u_lane_cl (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_tab      (r_cl),
        .i_frac     (r_frac),
        .i_flap_mag (r_af),
        .o_mag      (w_cl_mag),
        .o_neg      (w_cl_neg)
    );

    afl_lane u_lane_cd (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_tab      (r_cd),
        .i_frac     (r_frac),
        .i_flap_mag (r_af),
        .o_mag      (w_cd_mag),
        .o_neg      (w_cd_neg)
    );

    // Output register: apply sign and the out-of-range defaults
    always_comb begin
        n_ov = r_ctl[CTL_STAGES-1].valid;
        if (r_ctl[CTL_STAGES-1].in_range) begin
            n_lift = (w_cl_neg ^ r_ctl[CTL_STAGES-1].tail_neg)
                   ? -$signed({1'b0, w_cl_mag}) : $signed({1'b0, w_cl_mag});
            n_drag = w_cd_neg ? 18'(-w_cd_mag) : w_cd_mag;
        end else begin
            n_lift = '0;
            n_drag = OUT_DRAG_Q16;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CTL_STAGES; i++) begin
                r_ctl[i] <= '0;
            end
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ctl[0] <= n_ctl;
            for (int i = 1; i < CTL_STAGES; i++) begin
                r_ctl[i] <= r_ctl[i-1];
            end
            r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lift <= n_lift;
            r_drag <= n_drag;
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.lift_coeff = r_lift;
    assign o_out.drag_coeff = r_drag;

endmodule

[sv/afl_checker.sv]
// Port-level checks for the airfoil coefficient lookup, bound to the top level.
// Depends on afl_pkg and airfoil_coefficient_lookup_core.
module afl_checker import afl_pkg::*; (
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  i_in_ready,
    input logic  i_out_valid,
    input logic  i_out_ready,
    input t_lift i_lift,
    input t_drag i_drag
);

    // a result held back by the receiver stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // pipeline advances whenever the output register is free
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");

    // reset empties the pipeline
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // coefficients stay within +-2.0
    a_coeff_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_lift >= -19'sd131072) && (i_lift <= 19'sd131072)
                        && (i_drag <= 18'd131072))
        else $error("coefficient out of range");

endmodule

bind airfoil_coefficient_lookup_core afl_checker u_afl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_lift      (o_out.lift_coeff),
    .i_drag      (o_out.drag_coeff)
);
